@@ rtl/smsd_pkg.sv @@
package smsd_pkg;

  // Field widths of the stream items.
  localparam int SAMPLE_W  = 16;
  localparam int MEAN_W    = 25;
  localparam int SD_W      = 24;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 72;

  // Accumulation limits and result scaling.
  localparam int COUNT_LOG2 = 16;
  localparam int FRAC_BITS  = 8;

  // Derived datapath widths.
  localparam int CNT_W   = COUNT_LOG2 + 1;
  localparam int SUM_W   = SAMPLE_W + COUNT_LOG2 + 1;
  localparam int SQ_W    = 2 * SAMPLE_W + COUNT_LOG2;
  localparam int PROD_W  = SQ_W + CNT_W;
  localparam int DQ_W    = PROD_W + 2 * FRAC_BITS;
  localparam int MDIVD_W = SUM_W + FRAC_BITS;
  localparam int DIVR_W  = 2 * COUNT_LOG2;
  localparam int ROOT_W  = SD_W + 1;
  localparam int REM_W   = (DIVR_W > ROOT_W + 2) ? DIVR_W : ROOT_W + 2;
  localparam int AW      = REM_W + 2;
  localparam int STEP_W  = $clog2(DQ_W + 1);

  // Configuration register indexes.
  localparam logic REG_SIGNED_MODE  = 1'b0;
  localparam logic REG_WANT_STD_DEV = 1'b1;

  // Closing totals handed to the arithmetic sequencer.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] count;
    logic             dropped;
    logic             want_sd;
  } smsd_start_t;

  // Finished result from the sequencer.
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [SD_W-1:0]   sd;
    logic [CNT_W-1:0]  count;
    logic              overflow;
  } smsd_result_t;

endpackage

@@ rtl/smsd_calc.sv @@
module smsd_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  smsd_pkg::smsd_start_t start_req,
  output logic                 idle,
  output logic                 res_valid,
  output smsd_pkg::smsd_result_t res,
  input  logic                 res_ready
);

  localparam int SUM_W   = smsd_pkg::SUM_W;
  localparam int SQ_W    = smsd_pkg::SQ_W;
  localparam int CNT_W   = smsd_pkg::CNT_W;
  localparam int PROD_W  = smsd_pkg::PROD_W;
  localparam int DQ_W    = smsd_pkg::DQ_W;
  localparam int MDIVD_W = smsd_pkg::MDIVD_W;
  localparam int DIVR_W  = smsd_pkg::DIVR_W;
  localparam int ROOT_W  = smsd_pkg::ROOT_W;
  localparam int REM_W   = smsd_pkg::REM_W;
  localparam int AW      = smsd_pkg::AW;
  localparam int STEP_W  = smsd_pkg::STEP_W;
  localparam int MEAN_W  = smsd_pkg::MEAN_W;
  localparam int SD_W    = smsd_pkg::SD_W;

  localparam logic [MDIVD_W:0] NEG_LIM = (MDIVD_W + 1)'(1) << (MEAN_W - 1);
  localparam logic [MDIVD_W:0] POS_LIM = NEG_LIM - (MDIVD_W + 1)'(1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MDIV = 4'd2;
  localparam logic [3:0] S_MFIN = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_VDIV = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  sum_lat;
  logic [SQ_W-1:0]   sq_lat;
  logic [CNT_W-1:0]  n_lat;
  logic              ovf_lat;
  logic              want_lat;
  logic              neg;
  logic [SUM_W-1:0]  s_mag;
  logic [DIVR_W-1:0] divisor;
  logic [DIVR_W-1:0] dprod;
  logic [DQ_W-1:0]   dq;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic              sat_hi;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [SUM_W-1:0]  mplier;
  logic [MEAN_W-1:0] mean;

  logic              is_sqrt;
  logic [AW-1:0]     a_op;
  logic [AW-1:0]     b_op;
  logic [AW:0]       diff;
  logic              ge;
  logic [REM_W-1:0]  rem_step;
  logic              sub;
  logic [PROD_W-1:0] addend;
  logic [PROD_W-1:0] acc_sum;
  logic [SUM_W-1:0]  s_mag_c;
  logic [2*CNT_W-1:0] dprod_c;
  logic [MDIVD_W:0]  qc;
  logic [MDIVD_W:0]  lim;
  logic [MDIVD_W:0]  mag_sel;
  logic [MEAN_W-1:0] mean_c;
  logic              step_last;

  // Shared trial subtractor: one restoring step of division or square root.
  assign is_sqrt  = (state == S_SQRT);
  assign a_op     = is_sqrt ? {rem, dq[2*ROOT_W-1 -: 2]} : {1'b0, rem, dq[DQ_W-1]};
  assign b_op     = is_sqrt ? AW'({root, 2'b01}) : AW'(divisor);
  assign diff     = {1'b0, a_op} - {1'b0, b_op};
  assign ge       = ~diff[AW];
  assign rem_step = ge ? diff[REM_W-1:0] : a_op[REM_W-1:0];

  // Shift-and-add accumulator for n*Q and the subtraction of S*S.
  assign sub     = (state == S_MUL2);
  assign addend  = sub ? ~mcand : mcand;
  assign acc_sum = acc + addend + PROD_W'(sub);

  // Magnitude of the sum and the variance divisor n*(n-1).
  assign s_mag_c = sum_lat[SUM_W-1] ? SUM_W'(0) - sum_lat : sum_lat;
  assign dprod_c = (2*CNT_W)'(n_lat) * (2*CNT_W)'(n_lat - CNT_W'(1));

  // Mean rounding toward minus infinity and clamping to the field range.
  always_comb begin
    qc      = {1'b0, dq[MDIVD_W-1:0]} + (MDIVD_W + 1)'(neg && (rem != '0));
    lim     = neg ? NEG_LIM : POS_LIM;
    mag_sel = (qc > lim) ? lim : qc;
    if (n_lat == '0) begin
      mean_c = '0;
    end else if (neg) begin
      mean_c = MEAN_W'(0) - mag_sel[MEAN_W-1:0];
    end else begin
      mean_c = mag_sel[MEAN_W-1:0];
    end
  end

  assign step_last = (step == STEP_W'(1));

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            sum_lat  <= start_req.sum;
            sq_lat   <= start_req.sq;
            n_lat    <= start_req.count;
            ovf_lat  <= start_req.dropped;
            want_lat <= start_req.want_sd;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          neg     <= sum_lat[SUM_W-1];
          s_mag   <= s_mag_c;
          dprod   <= dprod_c[DIVR_W-1:0];
          divisor <= DIVR_W'(n_lat);
          dq      <= DQ_W'(s_mag_c) << (DQ_W - SUM_W);
          rem     <= '0;
          step    <= STEP_W'(MDIVD_W);
          state   <= S_MDIV;
        end
        S_MDIV: begin
          rem  <= rem_step;
          dq   <= {dq[DQ_W-2:0], ge};
          step <= step - STEP_W'(1);
          if (step_last) begin
            state <= S_MFIN;
          end
        end
        S_MFIN: begin
          mean <= mean_c;
          if (want_lat && (n_lat > CNT_W'(1))) begin
            acc    <= '0;
            mcand  <= PROD_W'(sq_lat);
            mplier <= SUM_W'(n_lat);
            step   <= STEP_W'(CNT_W);
            state  <= S_MUL1;
          end else begin
            root   <= '0;
            sat_hi <= 1'b0;
            state  <= S_DONE;
          end
        end
        S_MUL1, S_MUL2: begin
          if (mplier[0]) begin
            acc <= acc_sum;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step - STEP_W'(1);
          if (step_last) begin
            if (state == S_MUL1) begin
              mcand  <= PROD_W'(s_mag);
              mplier <= s_mag;
              step   <= STEP_W'(SUM_W);
              state  <= S_MUL2;
            end else begin
              divisor <= dprod;
              rem     <= '0;
              dq      <= DQ_W'(mplier[0] ? acc_sum : acc) << (2 * smsd_pkg::FRAC_BITS);
              step    <= STEP_W'(DQ_W);
              state   <= S_VDIV;
            end
          end
        end
        S_VDIV: begin
          rem  <= rem_step;
          dq   <= {dq[DQ_W-2:0], ge};
          step <= step - STEP_W'(1);
          if (step_last) begin
            sat_hi <= |dq[DQ_W-2:2*ROOT_W-1];
            rem    <= '0;
            root   <= '0;
            dq     <= {dq[DQ_W-2:0], ge};
            step   <= STEP_W'(ROOT_W);
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem  <= rem_step;
          root <= {root[ROOT_W-2:0], ge};
          dq   <= dq << 2;
          step <= step - STEP_W'(1);
          if (step_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result presentation.
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.mean     = mean;
  assign res.sd       = (sat_hi || root[ROOT_W-1]) ? {SD_W{1'b1}} : root[SD_W-1:0];
  assign res.count    = n_lat;
  assign res.overflow = ovf_lat;

endmodule

@@ rtl/sample_mean_std_dev.sv @@
// Samples that do not close a set are taken back to back, one per cycle, while the
// sequencer is idle. A closing sample drops s_tready until its result is in the
// output register: the mean divide runs, and, when the deviation is computed, the
// multiply passes (n*Q, then S*S), the variance divide and the root steps. The next
// sample is taken once the result is there, or later while the output register waits.
// Synchronous active-high reset clears the accumulators, sequencer and output valid.
module sample_mean_std_dev (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic                                cfg_wdata,
  // Sample stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [smsd_pkg::TDATA_IN_W-1:0]     s_tdata,   // [15:0] sample
  input  logic                                s_tlast,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [smsd_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [24:0] mean_value,
                                                         // [48:25] std_dev,
                                                         // [65:49] sample_count
  output logic                                m_tuser    // [0] overflow
);

  localparam int SAMPLE_W = smsd_pkg::SAMPLE_W;
  localparam int SUM_W    = smsd_pkg::SUM_W;
  localparam int SQ_W     = smsd_pkg::SQ_W;
  localparam int CNT_W    = smsd_pkg::CNT_W;

  logic                    signed_mode;
  logic                    want_std_dev;
  logic [SUM_W-1:0]        running_sum;
  logic [SQ_W-1:0]         running_square_sum;
  logic [CNT_W-1:0]        count_so_far;
  logic                    dropped_flag;

  logic                    p_valid;
  logic                    p_last;
  logic [SAMPLE_W:0]       p_x;
  logic [2*SAMPLE_W-1:0]   p_sq;

  logic                    accept;
  logic                    full;
  logic                    sneg;
  logic [SAMPLE_W-1:0]     smag;
  logic [2*SAMPLE_W-1:0]   sq_c;
  logic [SUM_W-1:0]        x_ext;
  logic [SUM_W-1:0]        sum_next;
  logic [SQ_W-1:0]         sq_next;

  logic                    calc_idle;
  logic                    res_valid;
  logic                    res_ready;
  smsd_pkg::smsd_start_t   start_req;
  smsd_pkg::smsd_result_t  res;
  smsd_pkg::smsd_result_t  out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode  <= 1'b1;
      want_std_dev <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        smsd_pkg::REG_SIGNED_MODE:  signed_mode  <= cfg_wdata;
        smsd_pkg::REG_WANT_STD_DEV: want_std_dev <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input handshake and sample decoding.
  assign s_tready = ~p_last & calc_idle;
  assign accept   = s_tvalid & s_tready;
  assign full     = count_so_far[CNT_W-1];
  assign sneg     = signed_mode & s_tdata[SAMPLE_W-1];
  assign smag     = sneg ? SAMPLE_W'(0) - s_tdata[SAMPLE_W-1:0] : s_tdata[SAMPLE_W-1:0];
  assign sq_c     = smag * smag;

  // Totals including the sample held in the square stage.
  assign x_ext    = {{(SUM_W - SAMPLE_W - 1){p_x[SAMPLE_W]}}, p_x};
  assign sum_next = running_sum + (p_valid ? x_ext : SUM_W'(0));
  assign sq_next  = running_square_sum + (p_valid ? SQ_W'(p_sq) : SQ_W'(0));

  // Square stage and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid            <= 1'b0;
      p_last             <= 1'b0;
      running_sum        <= '0;
      running_square_sum <= '0;
      count_so_far       <= '0;
      dropped_flag       <= 1'b0;
    end else begin
      p_valid <= accept & ~full;
      p_last  <= accept & s_tlast;
      if (accept) begin
        p_x  <= {sneg, s_tdata[SAMPLE_W-1:0]};
        p_sq <= sq_c;
        if (full) begin
          dropped_flag <= 1'b1;
        end else begin
          count_so_far <= count_so_far + CNT_W'(1);
        end
      end
      if (p_last) begin
        running_sum        <= '0;
        running_square_sum <= '0;
        count_so_far       <= '0;
        dropped_flag       <= 1'b0;
      end else begin
        running_sum        <= sum_next;
        running_square_sum <= sq_next;
      end
    end
  end

  // Closing request to the arithmetic sequencer.
  assign start_req.sum     = sum_next;
  assign start_req.sq      = sq_next;
  assign start_req.count   = count_so_far;
  assign start_req.dropped = dropped_flag;
  assign start_req.want_sd = want_std_dev;

  smsd_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .start     (p_last),
    .start_req (start_req),
    .idle      (calc_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register.
  assign res_ready = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
      out_res  <= res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = smsd_pkg::TDATA_OUT_W'({out_res.count, out_res.sd, out_res.mean});
  assign m_tuser = out_res.overflow;

endmodule
